// ----- hw/rtl/hsv2rgb_pkg.sv -----
// Shared types and fixed-point constants for the HSV to RGB converter.
package hsv2rgb_pkg;

    // Hue is in 1/16 degree: one 60-degree sector is 960 units, a full circle 5760.
    localparam int HUE_SECTOR = 960;
    localparam logic [12:0] HUE_FULL = 13'd5760;

    // Saturation and value are fractions over 255.
    localparam logic [7:0] SAT_SCALE = 8'd255;

    // The q and t products are scaled by 255 * 960.
    localparam logic [17:0] PROD_SCALE = 18'd244800;

    // The q and t numerators are divided as (num >> 6) / 3825.
    // 4386 is floor(2^24 / 3825), so the estimate is exact or one low.
    localparam logic [11:0] DIV_Q = 12'd3825;
    localparam logic [12:0] RECIP_Q = 13'd4386;

    // The p numerator is divided by 255.
    // 257 is floor(2^16 / 255), so the estimate is exact or one low.
    localparam logic [8:0] RECIP_P = 9'd257;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    // Load enables for the two register stages of a divider.
    typedef struct packed {
        logic est;
        logic fix;
    } t_div_en;

endpackage

// ----- hw/rtl/hsv_to_rgb_converter_top.sv -----
// HSV to RGB converter: six-stage pipeline from one pixel colour to 8-bit RGB.
// Throughput is one item per cycle while the output is not stalled.
// A stalled output holds its stage, and bubbles further up are still filled.
// Reset clears the stage valid bits only; data registers are not reset.
module hsv_to_rgb_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [12:0] i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    logic [6:1] r_vld;
    logic [6:1] w_en;

    // Stage 1: hue wrap, sector and fraction.
    logic [12:0]             w_hw;
    logic [12:0]             w_base;
    hsv2rgb_pkg::t_sector    w_sec;
    hsv2rgb_pkg::t_sector    r1_sec;
    logic [9:0]              r1_frac;
    logic [7:0]              r1_sat;
    logic [7:0]              r1_val;

    // Stage 2: first products.
    hsv2rgb_pkg::t_sector    r2_sec;
    logic [7:0]              r2_val;
    logic [17:0]             r2_sf;
    logic [17:0]             r2_sg;
    logic [15:0]             r2_x;

    // Stage 3: q and t numerators.
    hsv2rgb_pkg::t_sector    r3_sec;
    logic [7:0]              r3_val;
    logic [25:0]             r3_yq;
    logic [25:0]             r3_yt;
    logic [15:0]             r3_x;

    // Stages 4 and 5: division by constants.
    hsv2rgb_pkg::t_div_en    w_div_en;
    logic [23:0]             w_pprod;
    hsv2rgb_pkg::t_sector    r4_sec;
    logic [7:0]              r4_val;
    logic [15:0]             r4_x;
    logic [7:0]              r4_pest;
    logic [15:0]             w_pback;
    logic [15:0]             w_prem;
    logic [7:0]              n_p;
    hsv2rgb_pkg::t_sector    r5_sec;
    logic [7:0]              r5_val;
    logic [7:0]              r5_p;
    logic [7:0]              w_q;
    logic [7:0]              w_t;

    // Stage 6: channel routing.
    logic [7:0]              n_red;
    logic [7:0]              n_green;
    logic [7:0]              n_blue;
    logic [7:0]              r_red;
    logic [7:0]              r_green;
    logic [7:0]              r_blue;

    // A stage loads when it is empty or when the stage after it moves.
    assign w_en[6] = !r_vld[6] || !i_stall;
    assign w_en[5] = !r_vld[5] || w_en[6];
    assign w_en[4] = !r_vld[4] || w_en[5];
    assign w_en[3] = !r_vld[3] || w_en[4];
    assign w_en[2] = !r_vld[2] || w_en[3];
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign o_stall = !w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) r_vld[1] <= i_valid;
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
            if (w_en[4]) r_vld[4] <= r_vld[3];
            if (w_en[5]) r_vld[5] <= r_vld[4];
            if (w_en[6]) r_vld[6] <= r_vld[5];
        end
    end

    // Hues above the full circle wrap once; the result is always below 5760.
    assign w_hw = (i_hue >= hsv2rgb_pkg::HUE_FULL) ? (i_hue - hsv2rgb_pkg::HUE_FULL) : i_hue;

    always_comb begin
        if (w_hw < 13'(hsv2rgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsv2rgb_pkg::SEC_0;
            w_base = 13'd0;
        end else if (w_hw < 13'(2 * hsv2rgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsv2rgb_pkg::SEC_1;
            w_base = 13'(hsv2rgb_pkg::HUE_SECTOR);
        end else if (w_hw < 13'(3 * hsv2rgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsv2rgb_pkg::SEC_2;
            w_base = 13'(2 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (w_hw < 13'(4 * hsv2rgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsv2rgb_pkg::SEC_3;
            w_base = 13'(3 * hsv2rgb_pkg::HUE_SECTOR);
        end else if (w_hw < 13'(5 * hsv2rgb_pkg::HUE_SECTOR)) begin
            w_sec  = hsv2rgb_pkg::SEC_4;
            w_base = 13'(4 * hsv2rgb_pkg::HUE_SECTOR);
        end else begin
            w_sec  = hsv2rgb_pkg::SEC_5;
            w_base = 13'(5 * hsv2rgb_pkg::HUE_SECTOR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_sec  <= w_sec;
            r1_frac <= 10'(w_hw - w_base);
            r1_sat  <= i_saturation;
            r1_val  <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_sec <= r1_sec;
            r2_val <= r1_val;
            r2_sf  <= 18'(r1_sat) * 18'(r1_frac);
            r2_sg  <= 18'(r1_sat) * 18'(10'(hsv2rgb_pkg::HUE_SECTOR) - r1_frac);
            r2_x   <= 16'(r1_val) * 16'(hsv2rgb_pkg::SAT_SCALE - r1_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_sec <= r2_sec;
            r3_val <= r2_val;
            r3_yq  <= 26'(r2_val) * 26'(hsv2rgb_pkg::PROD_SCALE - r2_sf);
            r3_yt  <= 26'(r2_val) * 26'(hsv2rgb_pkg::PROD_SCALE - r2_sg);
            r3_x   <= r2_x;
        end
    end

    assign w_div_en.est = w_en[4];
    assign w_div_en.fix = w_en[5];

    hsv2rgb_qdiv u_div_q (
        .i_clk (i_clk),
        .i_en  (w_div_en),
        .i_num (r3_yq),
        .o_quo (w_q)
    );

    hsv2rgb_qdiv u_div_t (
        .i_clk (i_clk),
        .i_en  (w_div_en),
        .i_num (r3_yt),
        .o_quo (w_t)
    );

    assign w_pprod = 24'(r3_x) * 24'(hsv2rgb_pkg::RECIP_P);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_sec  <= r3_sec;
            r4_val  <= r3_val;
            r4_x    <= r3_x;
            r4_pest <= w_pprod[23:16];
        end
    end

    assign w_pback = 16'(r4_pest) * 16'(hsv2rgb_pkg::SAT_SCALE);
    assign w_prem  = r4_x - w_pback;
    assign n_p     = r4_pest + 8'(w_prem >= 16'(hsv2rgb_pkg::SAT_SCALE));

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_sec <= r4_sec;
            r5_val <= r4_val;
            r5_p   <= n_p;
        end
    end

    // With zero saturation p, q and t all equal value, so grey needs no special path.
    always_comb begin
        case (r5_sec)
            hsv2rgb_pkg::SEC_0: begin
                n_red = r5_val; n_green = w_t;    n_blue = r5_p;
            end
            hsv2rgb_pkg::SEC_1: begin
                n_red = w_q;    n_green = r5_val; n_blue = r5_p;
            end
            hsv2rgb_pkg::SEC_2: begin
                n_red = r5_p;   n_green = r5_val; n_blue = w_t;
            end
            hsv2rgb_pkg::SEC_3: begin
                n_red = r5_p;   n_green = w_q;    n_blue = r5_val;
            end
            hsv2rgb_pkg::SEC_4: begin
                n_red = w_t;    n_green = r5_p;   n_blue = r5_val;
            end
            default: begin
                n_red = r5_val; n_green = r5_p;   n_blue = w_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_vld[6];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ----- hw/rtl/hsv2rgb_qdiv.sv -----
// Two-stage divider of a q or t numerator by 255 * 960.
module hsv2rgb_qdiv (
    input  logic                 i_clk,
    input  hsv2rgb_pkg::t_div_en i_en,
    input  logic [25:0]          i_num,
    output logic [7:0]           o_quo
);

    logic [19:0] w_z;
    logic [31:0] w_prod;
    logic [19:0] w_back;
    logic [19:0] w_rem;
    logic [7:0]  n_quo;

    logic [19:0] r_z;
    logic [7:0]  r_est;
    logic [7:0]  r_quo;

    // 244800 = 64 * 3825, and nested floors give the same quotient.
    assign w_z    = i_num[25:6];
    assign w_prod = 32'(w_z) * 32'(hsv2rgb_pkg::RECIP_Q);

    always_ff @(posedge i_clk) begin
        if (i_en.est) begin
            r_z   <= w_z;
            r_est <= w_prod[31:24];
        end
    end

    // The estimate is at most one below the true quotient.
    assign w_back = 20'(r_est) * 20'(hsv2rgb_pkg::DIV_Q);
    assign w_rem  = r_z - w_back;
    assign n_quo  = r_est + 8'(w_rem >= 20'(hsv2rgb_pkg::DIV_Q));

    always_ff @(posedge i_clk) begin
        if (i_en.fix) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule
